/* src/omra_pkg.sv */
package omra_pkg;

    localparam int MAX_OBJECTS   = 64;
    localparam int IDX_W         = $clog2(MAX_OBJECTS);
    localparam int CNT_W         = $clog2(MAX_OBJECTS + 1);
    localparam int POS_FRAC_BITS = 16;

    // round(0.1 * 2^POS_FRAC_BITS)
    localparam logic [30:0] RADIUS_RESET =
        31'(((64'd1 << POS_FRAC_BITS) + 64'd5) / 64'd10);

    localparam logic [15:0] HITS_MAX = 16'hFFFF;

    localparam logic FUNC_OBSERVE = 1'b0;
    localparam logic FUNC_DELETE  = 1'b1;

    typedef enum logic [2:0] {
        ST_MERGED    = 3'd0,
        ST_CREATED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]         cls;
        logic [31:0]        ident;
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic signed [31:0] mean_z;
        logic [15:0]        hits;
        logic [15:0]        best;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* src/omra_ram.sv */
module omra_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/object_map_radius_association_unit.sv */
// Observe scans the entries in order and merges into the first match (three
// 48-step divisions, using the shared multiplier and the bit-serial divider),
// or else does a create or, with the table full, a drop. Delete scans for the
// id, shifts later entries down one place, and shrinks the table. One item at
// a time.
// Reset clears the table count, the next id and the radius to 0.1 m.
module object_map_radius_association_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [7:0]         class_id,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        confidence,
    input  logic [31:0]        target_id,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [31:0]        object_id,
    output logic signed [31:0] mean_x,
    output logic signed [31:0] mean_y,
    output logic signed [31:0] mean_z,
    output logic [15:0]        times_seen,
    output logic               best_raised,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_wdata
);

    import omra_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RSQ, S_RSQ2, S_RD, S_CHK, S_FAR,
        S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_SQ4,
        S_MUL, S_NUM, S_PREP, S_DIV, S_FIN, S_WB,
        S_CREATE, S_SRD, S_SWR, S_OUT
    } state_t;

    state_t state_reg;

    logic [30:0]        radius_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [31:0]        next_id_reg;

    logic               func_reg;
    logic [7:0]         class_reg;
    logic signed [31:0] pos_reg [3];
    logic [15:0]        conf_reg;
    logic [31:0]        target_reg;

    entry_t             ent_reg;
    logic               cls_hit_reg;
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic signed [65:0] prod_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        rr_reg;
    logic [1:0]         axis_reg;
    logic signed [48:0] num_reg;
    logic               neg_reg;
    logic [47:0]        div_reg;
    logic [16:0]        rem_reg;
    logic [5:0]         step_reg;
    logic signed [31:0] mnew_reg [3];

    logic [2:0]         res_status_reg;
    logic [31:0]        res_id_reg;
    logic signed [31:0] res_x_reg, res_y_reg, res_z_reg;
    logic [15:0]        res_hits_reg;
    logic               res_raised_reg;

    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic [31:0]        out_id_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic [15:0]        out_hits_reg;
    logic               out_raised_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    entry_t             rd_ent, wr_ent;

    logic signed [32:0] mul_a, mul_b;
    logic signed [32:0] r33;
    logic signed [31:0] mean_sel, pos_sel;
    logic [16:0]        dvs;
    logic [17:0]        trial;
    logic               trial_ge;
    logic [16:0]        rem_step;
    logic signed [48:0] mag;
    logic [31:0]        quo;
    logic [15:0]        hits_new;
    logic               raise;
    logic [CNT_W-1:0]   idx_inc;

    assign rd_ent  = entry_t'(ram_rdata);
    assign r33     = $signed({2'b00, radius_reg});
    assign idx_inc = CNT_W'(idx_reg + 1'b1);
    assign dvs     = {1'b0, ent_reg.hits} + 17'd1;
    assign hits_new = (ent_reg.hits == HITS_MAX) ? ent_reg.hits : ent_reg.hits + 16'd1;
    assign raise    = conf_reg > ent_reg.best;

    always_comb
    begin
        case (axis_reg)
            2'd0:    begin mean_sel = ent_reg.mean_x; pos_sel = pos_reg[0]; end
            2'd1:    begin mean_sel = ent_reg.mean_y; pos_sel = pos_reg[1]; end
            default: begin mean_sel = ent_reg.mean_z; pos_sel = pos_reg[2]; end
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_RSQ:   begin mul_a = r33;    mul_b = r33;    end
            S_SQ0:   begin mul_a = dx_reg; mul_b = dx_reg; end
            S_SQ1:   begin mul_a = dy_reg; mul_b = dy_reg; end
            S_SQ2:   begin mul_a = dz_reg; mul_b = dz_reg; end
            S_MUL:
            begin
                mul_a = {mean_sel[31], mean_sel};
                mul_b = $signed({17'd0, ent_reg.hits});
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // restoring divider step
    assign trial    = {rem_reg, div_reg[47]};
    assign trial_ge = trial >= {1'b0, dvs};
    assign rem_step = trial_ge ? 17'(trial - {1'b0, dvs}) : trial[16:0];
    assign mag      = num_reg[48] ? -num_reg : num_reg;
    assign quo      = div_reg[31:0];

    always_comb
    begin
        wr_ent    = ent_reg;
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_raddr = (state_reg == S_SRD) ? idx_inc[IDX_W-1:0] : idx_reg[IDX_W-1:0];
        case (state_reg)
            S_WB:
            begin
                ram_we        = 1'b1;
                wr_ent.mean_x = mnew_reg[0];
                wr_ent.mean_y = mnew_reg[1];
                wr_ent.mean_z = mnew_reg[2];
                wr_ent.hits   = hits_new;
                wr_ent.best   = raise ? conf_reg : ent_reg.best;
            end
            S_CREATE:
            begin
                ram_we        = (used_reg != CNT_W'(MAX_OBJECTS));
                ram_waddr     = used_reg[IDX_W-1:0];
                wr_ent.cls    = class_reg;
                wr_ent.ident  = next_id_reg;
                wr_ent.mean_x = pos_reg[0];
                wr_ent.mean_y = pos_reg[1];
                wr_ent.mean_z = pos_reg[2];
                wr_ent.hits   = 16'd1;
                wr_ent.best   = conf_reg;
            end
            S_SWR:
            begin
                ram_we = 1'b1;
                wr_ent = rd_ent;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
        ram_wdata = wr_ent;
    end

    omra_ram #(
        .W(ENTRY_W),
        .D(MAX_OBJECTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= RADIUS_RESET;
            used_reg      <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg   <= func;
                        class_reg  <= class_id;
                        pos_reg[0] <= pos_x;
                        pos_reg[1] <= pos_y;
                        pos_reg[2] <= pos_z;
                        conf_reg   <= confidence;
                        target_reg <= target_id;
                        idx_reg    <= '0;
                        state_reg  <= (func == FUNC_DELETE) ? S_RD : S_RSQ;
                    end
                end
                S_RSQ:
                begin
                    state_reg <= S_RSQ2;
                end
                S_RSQ2:
                begin
                    rr_reg    <= prod_reg[63:0];
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    if (idx_reg == used_reg)
                    begin
                        if (func_reg == FUNC_DELETE)
                        begin
                            res_status_reg <= ST_NOT_FOUND;
                            res_id_reg     <= '0;
                            res_x_reg      <= '0;
                            res_y_reg      <= '0;
                            res_z_reg      <= '0;
                            res_hits_reg   <= '0;
                            res_raised_reg <= 1'b0;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_CREATE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    ent_reg     <= rd_ent;
                    cls_hit_reg <= rd_ent.cls == class_reg;
                    dx_reg <= 33'(rd_ent.mean_x) - 33'(pos_reg[0]);
                    dy_reg <= 33'(rd_ent.mean_y) - 33'(pos_reg[1]);
                    dz_reg <= 33'(rd_ent.mean_z) - 33'(pos_reg[2]);
                    if (func_reg == FUNC_DELETE)
                    begin
                        if (rd_ent.ident == target_reg)
                        begin
                            res_status_reg <= ST_DELETED;
                            res_id_reg     <= rd_ent.ident;
                            res_x_reg      <= rd_ent.mean_x;
                            res_y_reg      <= rd_ent.mean_y;
                            res_z_reg      <= rd_ent.mean_z;
                            res_hits_reg   <= rd_ent.hits;
                            res_raised_reg <= 1'b0;
                            state_reg      <= S_SRD;
                        end
                        else
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FAR;
                    end
                end
                S_FAR:
                begin
                    // drop on class mismatch or any axis at or beyond the radius
                    if (!cls_hit_reg
                        || dx_reg >= r33 || dx_reg <= -r33
                        || dy_reg >= r33 || dy_reg <= -r33
                        || dz_reg >= r33 || dz_reg <= -r33)
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        state_reg <= S_SQ0;
                    end
                end
                S_SQ0:
                begin
                    state_reg <= S_SQ1;
                end
                S_SQ1:
                begin
                    acc_reg   <= prod_reg[63:0];
                    state_reg <= S_SQ2;
                end
                S_SQ2:
                begin
                    acc_reg   <= acc_reg + prod_reg[63:0];
                    state_reg <= S_SQ3;
                end
                S_SQ3:
                begin
                    acc_reg   <= acc_reg + prod_reg[63:0];
                    state_reg <= S_SQ4;
                end
                S_SQ4:
                begin
                    if (acc_reg < rr_reg)
                    begin
                        axis_reg  <= 2'd0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_RD;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_NUM;
                end
                S_NUM:
                begin
                    num_reg   <= $signed(prod_reg[48:0]) + 49'(pos_sel);
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    // round half away from zero on the magnitude
                    neg_reg   <= num_reg[48];
                    div_reg   <= mag[47:0] + {32'd0, dvs[16:1]};
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= rem_step;
                    div_reg  <= {div_reg[46:0], trial_ge};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd47)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    mnew_reg[axis_reg] <= neg_reg ? -$signed(quo) : $signed(quo);
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= S_WB;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_WB:
                begin
                    res_status_reg <= ST_MERGED;
                    res_id_reg     <= ent_reg.ident;
                    res_x_reg      <= mnew_reg[0];
                    res_y_reg      <= mnew_reg[1];
                    res_z_reg      <= mnew_reg[2];
                    res_hits_reg   <= hits_new;
                    res_raised_reg <= raise;
                    state_reg      <= S_OUT;
                end
                S_CREATE:
                begin
                    if (used_reg == CNT_W'(MAX_OBJECTS))
                    begin
                        res_status_reg <= ST_FULL;
                        res_id_reg     <= '0;
                        res_x_reg      <= '0;
                        res_y_reg      <= '0;
                        res_z_reg      <= '0;
                        res_hits_reg   <= '0;
                        res_raised_reg <= 1'b0;
                    end
                    else
                    begin
                        res_status_reg <= ST_CREATED;
                        res_id_reg     <= next_id_reg;
                        res_x_reg      <= pos_reg[0];
                        res_y_reg      <= pos_reg[1];
                        res_z_reg      <= pos_reg[2];
                        res_hits_reg   <= 16'd1;
                        res_raised_reg <= 1'b1;
                        used_reg       <= used_reg + 1'b1;
                        next_id_reg    <= next_id_reg + 32'd1;
                    end
                    state_reg <= S_OUT;
                end
                S_SRD:
                begin
                    // compact: move later entries down one place
                    if (idx_inc >= used_reg)
                    begin
                        used_reg  <= used_reg - 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SWR;
                    end
                end
                S_SWR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_SRD;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_id_reg     <= res_id_reg;
                        out_x_reg      <= res_x_reg;
                        out_y_reg      <= res_y_reg;
                        out_z_reg      <= res_z_reg;
                        out_hits_reg   <= res_hits_reg;
                        out_raised_reg <= res_raised_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign object_id   = out_id_reg;
    assign mean_x      = out_x_reg;
    assign mean_y      = out_y_reg;
    assign mean_z      = out_z_reg;
    assign times_seen  = out_hits_reg;
    assign best_raised = out_raised_reg;

endmodule

/* sim/object_map_radius_association_unit_tb.sv */
module object_map_radius_association_unit_tb;
    import omra_pkg::*;

    localparam int IDLE_LIMIT = 200000;
    localparam int N_RANDOM   = 1190;

    typedef struct {
        logic               func;
        logic [7:0]         cls;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        conf;
        logic [31:0]        tid;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        ident;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
        logic [15:0]        hits;
        logic               raised;
    } answer_t;

    // directed row: item, optional typed-in answer
    typedef struct {
        item_t   it;
        logic    typed;
        answer_t ans;
        logic    set_radius;
        logic [30:0] radius;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = 1'b0;
    logic [7:0] class_id = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [15:0] confidence = '0;
    logic [31:0] target_id = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] status;
    logic [31:0] object_id;
    logic signed [31:0] mean_x, mean_y, mean_z;
    logic [15:0] times_seen;
    logic best_raised;
    logic cfg_we = 1'b0;
    logic [30:0] cfg_wdata = '0;

    object_map_radius_association_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .class_id(class_id),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .confidence(confidence), .target_id(target_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .object_id(object_id),
        .mean_x(mean_x), .mean_y(mean_y), .mean_z(mean_z),
        .times_seen(times_seen), .best_raised(best_raised),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the object map
    entry_t      map_tab[MAX_OBJECTS];
    int          map_used;
    logic [31:0] map_next_id;
    logic [30:0] map_radius;

    answer_t     pending_answers[$];
    int          failures;
    int          idle_cycles;
    logic        hold_off;
    logic        noisy_rx;

    function automatic logic signed [31:0] blend_mean(logic signed [31:0] m,
                                                      logic signed [31:0] p,
                                                      logic [15:0] n);
        longint num, d, q;
        num = longint'(m) * longint'({48'd0, n}) + longint'(p);
        d = longint'({48'd0, n}) + 1;
        if (num >= 0)
            q = (num + d / 2) / d;
        else
            q = -((-num + d / 2) / d);
        return q[31:0];
    endfunction

    function automatic logic close_to(int k, item_t it);
        longint unsigned r, ax, ay, az;
        longint dx, dy, dz;
        r = {33'd0, map_radius};
        dx = longint'(map_tab[k].mean_x) - longint'(it.px);
        dy = longint'(map_tab[k].mean_y) - longint'(it.py);
        dz = longint'(map_tab[k].mean_z) - longint'(it.pz);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        az = dz < 0 ? -dz : dz;
        if (ax >= r || ay >= r || az >= r)
            return 1'b0;
        return ax * ax + ay * ay + az * az < r * r;
    endfunction

    function automatic answer_t entry_answer(status_t st, int k, logic raised);
        answer_t a;
        a.status = st;
        a.ident = map_tab[k].ident;
        a.mx = map_tab[k].mean_x;
        a.my = map_tab[k].mean_y;
        a.mz = map_tab[k].mean_z;
        a.hits = map_tab[k].hits;
        a.raised = raised;
        return a;
    endfunction

    function automatic answer_t apply_item(item_t it);
        answer_t a;
        logic    raised;
        a = '{default: '0};
        if (it.func == FUNC_DELETE) begin
            for (int k = 0; k < map_used; k++) begin
                if (map_tab[k].ident == it.tid) begin
                    a = entry_answer(ST_DELETED, k, 1'b0);
                    for (int j = k; j + 1 < map_used; j++)
                        map_tab[j] = map_tab[j + 1];
                    map_used--;
                    return a;
                end
            end
            a.status = ST_NOT_FOUND;
            return a;
        end
        for (int k = 0; k < map_used; k++) begin
            if (map_tab[k].cls == it.cls && close_to(k, it)) begin
                map_tab[k].mean_x = blend_mean(map_tab[k].mean_x, it.px, map_tab[k].hits);
                map_tab[k].mean_y = blend_mean(map_tab[k].mean_y, it.py, map_tab[k].hits);
                map_tab[k].mean_z = blend_mean(map_tab[k].mean_z, it.pz, map_tab[k].hits);
                if (map_tab[k].hits != HITS_MAX)
                    map_tab[k].hits++;
                raised = it.conf > map_tab[k].best;
                if (raised)
                    map_tab[k].best = it.conf;
                return entry_answer(ST_MERGED, k, raised);
            end
        end
        if (map_used >= MAX_OBJECTS) begin
            a.status = ST_FULL;
            return a;
        end
        map_tab[map_used] = '{cls: it.cls, ident: map_next_id, mean_x: it.px,
                              mean_y: it.py, mean_z: it.pz, hits: 16'd1,
                              best: it.conf};
        map_used++;
        map_next_id++;
        return entry_answer(ST_CREATED, map_used - 1, 1'b1);
    endfunction

    // receiver: random stalls, long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (noisy_rx)
            out_stall <= ($urandom_range(0, 9) < 3);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_answers.size() == 0) begin
                $error("result with nothing expected, status %0d", status);
                failures++;
            end else begin
                e = pending_answers.pop_front();
                if (status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, status); failures++;
                end
                if (object_id !== e.ident) begin
                    $error("object_id exp %0d got %0d", e.ident, object_id); failures++;
                end
                if (mean_x !== e.mx) begin
                    $error("mean_x exp %0d got %0d", e.mx, mean_x); failures++;
                end
                if (mean_y !== e.my) begin
                    $error("mean_y exp %0d got %0d", e.my, mean_y); failures++;
                end
                if (mean_z !== e.mz) begin
                    $error("mean_z exp %0d got %0d", e.mz, mean_z); failures++;
                end
                if (times_seen !== e.hits) begin
                    $error("times_seen exp %0d got %0d", e.hits, times_seen); failures++;
                end
                if (best_raised !== e.raised) begin
                    $error("best_raised exp %0d got %0d", e.raised, best_raised);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_radius(logic [30:0] r);
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
        map_radius = r;
    endtask

    task automatic drain();
        wait (pending_answers.size() == 0);
        repeat (2) @(posedge clk);
    endtask

    function automatic int gap_len();
        int g;
        g = $urandom_range(0, 99);
        if (g < 50)
            return 0;
        else if (g < 95)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 300);
    endfunction

    task automatic send_item(item_t it, logic typed, answer_t ans, logic gaps);
        answer_t p;
        int      g;
        in_valid <= 1'b1;
        func <= it.func;
        class_id <= it.cls;
        pos_x <= it.px;
        pos_y <= it.py;
        pos_z <= it.pz;
        confidence <= it.conf;
        target_id <= it.tid;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        p = apply_item(it);
        if (typed && p != ans) begin
            $error("predictor disagrees with typed row, status %0d", p.status);
            failures++;
        end
        if (typed)
            p = ans;
        pending_answers = {pending_answers, p};
        if (gaps && $urandom_range(0, 1)) begin
            g = gap_len();
            if (g > 0) begin
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    endtask

    function automatic item_t obs(logic [7:0] c, logic signed [31:0] x,
                                  logic signed [31:0] y, logic signed [31:0] z,
                                  logic [15:0] cf);
        return '{func: FUNC_OBSERVE, cls: c, px: x, py: y, pz: z, conf: cf,
                 tid: $urandom};
    endfunction

    function automatic item_t del(logic [31:0] id);
        return '{func: FUNC_DELETE, cls: 8'($urandom), px: $urandom, py: $urandom,
                 pz: $urandom, conf: 16'($urandom), tid: id};
    endfunction

    function automatic item_t random_item(logic [7:0] ncls, int spread);
        item_t it;
        int    k;
        if ($urandom_range(0, 99) < 12 && map_used > 0)
            return del(map_tab[$urandom_range(0, map_used - 1)].ident);
        if ($urandom_range(0, 99) < 3)
            return del($urandom);
        if ($urandom_range(0, 99) < 8) begin
            it = obs(8'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
            return it;
        end
        it = obs(8'($urandom_range(0, ncls)), $urandom_range(0, 8) * 32'sd60000,
                 $urandom_range(0, 8) * 32'sd60000, -$urandom_range(0, 4) * 32'sd60000,
                 16'($urandom));
        if (map_used > 0 && $urandom_range(0, 1)) begin
            k = $urandom_range(0, map_used - 1);
            it.cls = map_tab[k].cls;
            it.px = map_tab[k].mean_x + $signed($urandom_range(0, spread)) - spread / 2;
            it.py = map_tab[k].mean_y + $signed($urandom_range(0, spread)) - spread / 2;
            it.pz = map_tab[k].mean_z + $signed($urandom_range(0, spread)) - spread / 2;
        end
        return it;
    endfunction

    row_t    rows[$];
    answer_t zero_ans;

    initial
    begin
        row_t r;
        item_t it;
        failures = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        noisy_rx = 1'b0;
        map_used = 0;
        map_next_id = '0;
        map_radius = RADIUS_RESET;
        zero_ans = '{default: '0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // delete on empty map, first create, then merge at the extremes
        r = '{it: del(32'd0), typed: 1'b1, ans: '{status: ST_NOT_FOUND, default: '0},
              set_radius: 1'b0, radius: '0};
        rows = {rows, r};
        r.it = obs(8'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 16'hFFFF);
        r.ans = '{status: ST_CREATED, ident: 32'd0, mx: 32'sh7FFFFFFF, my: 32'sh80000000,
                  mz: 32'sd0, hits: 16'd1, raised: 1'b1};
        rows = {rows, r};
        r.it = obs(8'hFF, 32'sd0, 32'sd0, 32'sd0, 16'd0);
        r.ans = '{status: ST_CREATED, ident: 32'd1, mx: 32'sd0, my: 32'sd0, mz: 32'sd0,
                  hits: 16'd1, raised: 1'b1};
        rows = {rows, r};
        r.typed = 1'b0;
        r.it = obs(8'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1, 16'hFFFF);
        rows = {rows, r};
        r.it = obs(8'hFF, 32'sd100, -32'sd100, 32'sd3, 16'd5);
        rows = {rows, r};
        r.it = obs(8'hFF, -32'sd7, 32'sd1, -32'sd1, 16'd5);
        rows = {rows, r};
        r.it = obs(8'h0F, 32'sd6554, 32'sd0, 32'sd0, 16'd1);   // radius edge vs class 0xFF
        rows = {rows, r};
        r.it = del(32'd1);
        r.typed = 1'b1;
        r.ans = '{status: ST_DELETED, ident: 32'd1, mx: 32'sd31, my: -32'sd33, mz: 32'sd1,
                  hits: 16'd3, raised: 1'b0};
        rows = {rows, r};
        r.typed = 1'b0;
        r.it = del(32'hFFFFFFFF);
        rows = {rows, r};
        // zero radius: every observe creates
        r.set_radius = 1'b1;
        r.radius = 31'd0;
        r.it = obs(8'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1, 16'hFFFF);
        rows = {rows, r};
        r.set_radius = 1'b0;
        rows = {rows, r};
        // widest radius: far points merge
        r.set_radius = 1'b1;
        r.radius = 31'h7FFFFFFF;
        r.it = obs(8'h0F, -32'sd1000000, 32'sd5000000, 32'sh7FFF0000, 16'h8000);
        rows = {rows, r};
        r.set_radius = 1'b0;
        r.it = obs(8'h0F, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h7FFF);
        rows = {rows, r};

        foreach (rows[i]) begin
            if (rows[i].set_radius) begin
                in_valid <= 1'b0;
                drain();
                write_radius(rows[i].radius);
            end
            send_item(rows[i].it, rows[i].typed, rows[i].ans, 1'b0);
        end
        in_valid <= 1'b0;
        drain();

        // fill the table to the brim with zero radius and force drops
        write_radius(31'd0);
        while (map_used < MAX_OBJECTS)
            send_item(obs(8'($urandom), $urandom, $urandom, $urandom, 16'($urandom)),
                      1'b0, zero_ans, 1'b0);
        send_item(obs(8'd3, 32'sd0, 32'sd0, 32'sd0, 16'd0), 1'b1,
                  '{status: ST_FULL, default: '0}, 1'b0);
        // delete everything in random order to exercise shifts
        while (map_used > 0)
            send_item(del(map_tab[$urandom_range(0, map_used - 1)].ident), 1'b0,
                      zero_ans, 1'b0);
        in_valid <= 1'b0;
        drain();

        // long receiver hold-off while the sender keeps offering
        write_radius(31'd200000);
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 20; n++)
                send_item(random_item(8'd3, 100000), 1'b0, zero_ans, 1'b0);
        join
        in_valid <= 1'b0;
        drain();

        noisy_rx = 1'b1;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_radius(31'd6554);
                1: write_radius(31'd200000);
                2: write_radius(31'd1);
                3: write_radius(31'h7FFFFFFF);
                default: write_radius(31'($urandom));
            endcase
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                it = random_item(phase == 2 ? 8'd1 : 8'd5,
                                 phase == 2 ? 2 : 300000);
                send_item(it, 1'b0, zero_ans, 1'b1);
                if (n % 40 == 39)
                    noisy_rx = ~noisy_rx;
            end
            in_valid <= 1'b0;
            drain();
        end
        noisy_rx = 1'b0;

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
